@@ src/dial_indicator_serial_decoder_unit_assert.svh @@
// Assertion macros for the checker file dis_checker.sv.
// Each macro samples on clk_i and is switched off while rst_ni is low.
`ifndef DIAL_INDICATOR_SERIAL_DECODER_UNIT_ASSERT_SVH
`define DIAL_INDICATOR_SERIAL_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dis_pkg.sv @@
`default_nettype none
package dis_pkg;

  // frame geometry
  localparam int FrameBits = 24;
  localparam int MaxFrameBits = 32;
  localparam int InchBit = 23;
  localparam int SignBit = 20;
  localparam int BitCntW = $clog2(FrameBits + 1);

  // field widths
  localparam int SampleW = 10;
  localparam int ActionW = 2;
  localparam int PosW = 21;
  localparam int CountW = 16;

  localparam logic [SampleW-1:0] ThresholdReset = SampleW'(140);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // configuration port
  localparam int PAddrW = 3;
  localparam int PDataW = 32;
  localparam logic RegThreshold = 1'b0;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_DONE  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'b001,
    PH_WAIT_LOW  = 3'b010,
    PH_WAIT_HIGH = 3'b100
  } phase_e;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic                   inch_mode;
    logic [CountW-1:0]      reading_count;
  } result_t;

endpackage
`default_nettype wire

@@ src/dis_in_if.sv @@
`default_nettype none
interface dis_in_if;
  import dis_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [SampleW-1:0] clock_sample;
  logic [SampleW-1:0] data_sample;

  modport source (output valid, output action, output clock_sample, output data_sample,
                  input ready);
  modport sink (input valid, input action, input clock_sample, input data_sample,
                output ready);
endinterface
`default_nettype wire

@@ src/dis_out_if.sv @@
`default_nettype none
interface dis_out_if;
  import dis_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] position;
  logic                   inch_mode;
  logic [CountW-1:0]      reading_count;

  modport source (output valid, output position, output inch_mode, output reading_count,
                  input ready);
  modport sink (input valid, input position, input inch_mode, input reading_count,
                output ready);
endinterface
`default_nettype wire

@@ src/dial_indicator_serial_decoder_unit.sv @@
`default_nettype none
// Serial frame decoder for a dial indicator or caliper, fed by converter samples.
// in_i carries one sample step per word: an action (tick, start, done) plus the
// sampled levels of the indicator clock and data lines. out_o carries one word per
// completed frame: signed position, inch flag and the reading count.
// The APB port holds the logic-one threshold at address 0; pready is always high.
// Throughput: one input word per cycle while in_i.ready is high. The whole step
// (threshold compares, phase update, shift and count) sits between the state
// registers and the result register, so the result of the input word that
// completes the frame is registered in the result register or the skid word.
// Stall: the result register is backed by one skid word. Input words keep flowing
// while a result waits; in_i.ready drops only when both the result register and
// the skid word are full, and rises again once out_o takes a word.
// Reset (rst_ni low, asynchronous): phase goes idle, the bit counter and reading
// count clear, the threshold returns to 140 and both output words are dropped.
module dial_indicator_serial_decoder_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  dis_in_if.sink                          in_i,
  dis_out_if.source                       out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dis_pkg::PAddrW-1:0] paddr,
  input  wire logic [dis_pkg::PDataW-1:0] pwdata,
  output logic      [dis_pkg::PDataW-1:0] prdata,
  output logic                            pready
);
  import dis_pkg::*;

  // configuration
  logic [SampleW-1:0] thresh_q;

  // decoder state
  phase_e               phase_q, phase_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic [BitCntW-1:0]   bits_q, bits_d;
  logic [CountW-1:0]    count_q, count_d;

  // output words
  logic    main_v_q, main_v_d, skid_v_q, skid_v_d;
  result_t main_q, main_d, skid_q, skid_d;

  logic                  accept, take, res_valid, clk_low, clk_high, dat_one;
  result_t               res;
  logic [MaxFrameBits-1:0] frame_ext;
  logic [PosW-1:0]       mag_ext;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[PAddrW-1])
      RegThreshold: prdata = PDataW'(thresh_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThresholdReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PAddrW-1] == RegThreshold) begin
      thresh_q <= pwdata[SampleW-1:0];
    end
  end

  // Hold off input only when both output words are occupied.
  assign in_i.ready = !skid_v_q;
  assign accept = in_i.valid && in_i.ready;
  assign take = main_v_q && out_o.ready;

  assign clk_low  = in_i.clock_sample <= thresh_q;
  assign clk_high = in_i.clock_sample >= thresh_q;
  assign dat_one  = in_i.data_sample > thresh_q;

  // One step of the edge search per word.
  always_comb begin
    phase_d   = phase_q;
    frame_d   = frame_q;
    bits_d    = bits_q;
    count_d   = count_q;
    res_valid = 1'b0;
    if (accept) begin
      // done clears the count in every phase, before anything else acts
      if (in_i.action == ACT_DONE) begin
        count_d = '0;
      end
      unique case (phase_q)
        PH_IDLE: begin
          if (in_i.action == ACT_START) begin
            if (count_d != CountMax) begin
              count_d = count_d + CountW'(1);
            end
            frame_d = '0;
            bits_d  = '0;
            phase_d = PH_WAIT_LOW;
          end
        end
        PH_WAIT_LOW: begin
          if (clk_low) begin
            phase_d = PH_WAIT_HIGH;
          end
        end
        PH_WAIT_HIGH: begin
          if (clk_high) begin
            // rising edge: shift in the data bit, LSB first
            frame_d = {dat_one, frame_q[FrameBits-1:1]};
            phase_d = PH_WAIT_LOW;
            if (bits_q == BitCntW'(FrameBits - 1)) begin
              res_valid = 1'b1;
              bits_d    = '0;
              phase_d   = PH_IDLE;
            end else begin
              bits_d = bits_q + BitCntW'(1);
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Unpack the completed frame; bits beyond a short frame read as zero.
  assign frame_ext = MaxFrameBits'(frame_d);
  assign mag_ext   = PosW'(frame_ext[SignBit-1:0]);

  always_comb begin
    res.position      = frame_ext[SignBit] ? $signed(PosW'(0) - mag_ext) : $signed(mag_ext);
    res.inch_mode     = frame_ext[InchBit];
    res.reading_count = count_d;
  end

  // Result register plus skid word.
  always_comb begin
    main_v_d = main_v_q;
    main_d   = main_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!main_v_q || take) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_v_d = res_valid;
        skid_d   = res;
      end else begin
        main_v_d = res_valid;
        main_d   = res;
      end
    end else if (res_valid) begin
      skid_v_d = 1'b1;
      skid_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bits_q   <= '0;
      count_q  <= '0;
      frame_q  <= '0;
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      bits_q   <= bits_d;
      count_q  <= count_d;
      frame_q  <= frame_d;
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_o.valid         = main_v_q;
  assign out_o.position      = main_q.position;
  assign out_o.inch_mode     = main_q.inch_mode;
  assign out_o.reading_count = main_q.reading_count;

endmodule
`default_nettype wire

@@ src/dis_checker.sv @@
`default_nettype none
`include "dial_indicator_serial_decoder_unit_assert.svh"
module dis_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic signed [dis_pkg::PosW-1:0] out_position_i,
  input wire logic                       out_inch_i,
  input wire logic [dis_pkg::CountW-1:0] out_count_i
);
  import dis_pkg::*;

  // a waiting result stays put
  `DIS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "output word dropped")
  `DIS_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i,
    $stable(out_position_i) && $stable(out_inch_i) && $stable(out_count_i),
    "output word changed under stall")
  // a fresh result only follows an accepted word
  `DIS_ASSERT_NOW(a_res_cause, $rose(out_valid_i), $past(in_valid_i && in_ready_i),
    "result without input word")
  // input is held off only behind a full result register
  `DIS_ASSERT_NOW(a_ready_stall, !in_ready_i, out_valid_i, "input stalled with no result")

endmodule

bind dial_indicator_serial_decoder_unit dis_checker u_dis_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_position_i (out_o.position),
  .out_inch_i     (out_o.inch_mode),
  .out_count_i    (out_o.reading_count)
);
`default_nettype wire
